FILE: sv/sc2a_pkg.sv
// Shared constants, types and key tables for the scancode translator.
// Used by sc2a_keymap and scancode_to_ascii_with_modifiers; no dependencies.
`default_nettype none

package sc2a_pkg;

  // Special scancodes
  localparam logic [7:0] CODE_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] CODE_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] CODE_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] CODE_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] CODE_CAPS_MAKE    = 8'h3A;
  localparam logic [7:0] CODE_BACKSPACE    = 8'h0E;
  localparam logic [7:0] CODE_TAB          = 8'h0F;
  localparam int         RELEASE_BIT       = 7;
  localparam logic [7:0] MAP_SIZE          = 8'h3A;

  // Event kinds
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_CHAR = 2'd1;
  localparam logic [1:0] EV_BKSP = 2'd2;
  localparam logic [1:0] EV_TAB  = 2'd3;

  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic shift;
    logic caps;
  } mods_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] ch;
  } result_t;

  // Unshifted character per make code; zero means unmapped.
  function automatic logic [6:0] plain_char(input logic [5:0] code);
    logic [6:0] c;
    case (code)
      6'h02: c = 7'h31;  6'h03: c = 7'h32;  6'h04: c = 7'h33;  6'h05: c = 7'h34;
      6'h06: c = 7'h35;  6'h07: c = 7'h36;  6'h08: c = 7'h37;  6'h09: c = 7'h38;
      6'h0A: c = 7'h39;  6'h0B: c = 7'h30;  6'h0C: c = 7'h2D;  6'h0D: c = 7'h3D;
      6'h10: c = 7'h71;  6'h11: c = 7'h77;  6'h12: c = 7'h65;  6'h13: c = 7'h72;
      6'h14: c = 7'h74;  6'h15: c = 7'h79;  6'h16: c = 7'h75;  6'h17: c = 7'h69;
      6'h18: c = 7'h6F;  6'h19: c = 7'h70;  6'h1A: c = 7'h5B;  6'h1B: c = 7'h5D;
      6'h1C: c = 7'h0A;
      6'h1E: c = 7'h61;  6'h1F: c = 7'h73;  6'h20: c = 7'h64;  6'h21: c = 7'h66;
      6'h22: c = 7'h67;  6'h23: c = 7'h68;  6'h24: c = 7'h6A;  6'h25: c = 7'h6B;
      6'h26: c = 7'h6C;  6'h27: c = 7'h3B;  6'h28: c = 7'h27;  6'h29: c = 7'h60;
      6'h2B: c = 7'h5C;  6'h2C: c = 7'h7A;  6'h2D: c = 7'h78;  6'h2E: c = 7'h63;
      6'h2F: c = 7'h76;  6'h30: c = 7'h62;  6'h31: c = 7'h6E;  6'h32: c = 7'h6D;
      6'h33: c = 7'h2C;  6'h34: c = 7'h2E;  6'h35: c = 7'h2F;  6'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Shifted symbol for non-letter keys; zero means same as unshifted.
  function automatic logic [6:0] shift_char(input logic [5:0] code);
    logic [6:0] c;
    case (code)
      6'h02: c = 7'h21;  6'h03: c = 7'h40;  6'h04: c = 7'h23;  6'h05: c = 7'h24;
      6'h06: c = 7'h25;  6'h07: c = 7'h5E;  6'h08: c = 7'h26;  6'h09: c = 7'h2A;
      6'h0A: c = 7'h28;  6'h0B: c = 7'h29;  6'h0C: c = 7'h5F;  6'h0D: c = 7'h2B;
      6'h1A: c = 7'h7B;  6'h1B: c = 7'h7D;  6'h27: c = 7'h3A;  6'h28: c = 7'h22;
      6'h29: c = 7'h7E;  6'h2B: c = 7'h7C;  6'h33: c = 7'h3C;  6'h34: c = 7'h3E;
      6'h35: c = 7'h3F;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/scancode_to_ascii_with_modifiers.sv
// Top level: set-1 scancode to ASCII translator with shift and caps-lock state.
// Depends on sc2a_pkg and sc2a_keymap.
//
//   channel  dir  word fields (lowest bit up)
//   s_*      in   tdata[7:0] scan_byte
//   m_*      out  tdata[1:0] event_kind, [8:2] char_code, [15:9] zero
//
// One word per cycle sustained while m does not stall. The path is input register
// -> keymap lookup -> result register, and m_tvalid rises as a word enters the
// result register; the modifier flags update as a word moves into it.
// rst clears the modifier flags and both valid bits.
// A stall on m holds the result register and the input register; s_tready
// stays high while the input stage can drain or is empty.
`default_nettype none

module scancode_to_ascii_with_modifiers import sc2a_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // [7:0] scan_byte
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata    // [1:0] event_kind, [8:2] char_code
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;

  logic       left_shift_held;
  logic       right_shift_held;
  logic       caps_active;
  mods_t      mods;
  result_t    lookup;
  result_t    out_word;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  assign mods = '{shift: (left_shift_held || right_shift_held), caps: caps_active};

  sc2a_keymap u_keymap (
    .code   (in_byte),
    .mods   (mods),
    .result (lookup)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // Modifier flags follow the word leaving the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_shift_held  <= 1'b0;
      right_shift_held <= 1'b0;
      caps_active      <= 1'b0;
    end else if (advance) begin
      case (in_byte)
        CODE_LSHIFT_MAKE:  left_shift_held  <= 1'b1;
        CODE_LSHIFT_BREAK: left_shift_held  <= 1'b0;
        CODE_RSHIFT_MAKE:  right_shift_held <= 1'b1;
        CODE_RSHIFT_BREAK: right_shift_held <= 1'b0;
        CODE_CAPS_MAKE:    caps_active      <= !caps_active;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= lookup;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - 9){1'b0}}, out_word.ch, out_word.kind};

endmodule

`default_nettype wire

FILE: sv/sc2a_keymap.sv
// Combinational translation of one scancode byte under the current modifiers.
// Depends on sc2a_pkg for codes, tables and the result type.
`default_nettype none

module sc2a_keymap import sc2a_pkg::*; (
  input  wire logic [7:0] code,
  input  wire mods_t      mods,
  output result_t         result
);

  logic [6:0] plain;
  logic [6:0] shifted;
  logic [6:0] ch;
  logic       in_map;

  assign in_map  = (code < MAP_SIZE);
  assign plain   = plain_char(code[5:0]);
  assign shifted = shift_char(code[5:0]);

  always_comb begin
    if (!in_map) begin
      ch = 7'h00;
    end else if (plain inside {[7'h61:7'h7A]}) begin
      // letters: shift XOR caps picks upper case
      ch = (mods.shift != mods.caps) ? (plain - 7'h20) : plain;
    end else if (mods.shift && shifted != 7'h00) begin
      ch = shifted;
    end else begin
      ch = plain;
    end
  end

  always_comb begin
    result = '{kind: EV_NONE, ch: 7'h00};
    case (code)
      CODE_LSHIFT_MAKE, CODE_LSHIFT_BREAK, CODE_RSHIFT_MAKE, CODE_RSHIFT_BREAK,
      CODE_CAPS_MAKE: begin
        result = '{kind: EV_NONE, ch: 7'h00};
      end
      CODE_BACKSPACE: begin
        result = '{kind: EV_BKSP, ch: 7'h00};
      end
      CODE_TAB: begin
        result = '{kind: EV_TAB, ch: 7'h00};
      end
      default: begin
        // drop release codes and unmapped make codes
        if (!code[RELEASE_BIT] && ch != 7'h00) begin
          result = '{kind: EV_CHAR, ch: ch};
        end
      end
    endcase
  end

endmodule

`default_nettype wire
